// ----- hw/rtl/uvl_pkg.sv -----
// Shared types, constants and byte-class functions for the UTF-8 validator with Latin-1 repair.
`default_nettype none

package uvl_pkg;

  localparam int unsigned MaxOut = 8;

  localparam logic [7:0] LeadTwoLo   = 8'hC2;
  localparam logic [7:0] LeadTwoHi   = 8'hDF;
  localparam logic [7:0] LeadThreeLo = 8'hE0;
  localparam logic [7:0] LeadThreeHi = 8'hEF;
  localparam logic [7:0] LeadSurr    = 8'hED;
  localparam logic [7:0] LeadFourLo  = 8'hF0;
  localparam logic [7:0] LeadFourHi  = 8'hF4;
  localparam logic [7:0] ContE0Min   = 8'hA0;
  localparam logic [7:0] ContF0Min   = 8'h90;
  localparam logic [7:0] ContF4Max   = 8'h8F;
  localparam logic [7:0] Latin1Hi    = 8'hC0;
  localparam logic [7:0] Latin1Mask  = 8'h3F;
  localparam logic [7:0] ContTag     = 8'h80;
  localparam logic [7:0] ContMask    = 8'hC0;

  // One queue entry: all result bytes caused by one input byte.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [3:0]             count;
    logic                   fin;
  } uvl_entry_t;

  // Total sequence length for a lead byte, 0 when the byte cannot lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= LeadTwoLo && b <= LeadTwoHi) len = 3'd2;
    else if (b >= LeadThreeLo && b <= LeadThreeHi) len = 3'd3;
    else if (b >= LeadFourLo && b <= LeadFourHi) len = 3'd4;
    return len;
  endfunction

  // Whether b may follow lead at continuation position pos (1 is first).
  function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                   input logic [7:0] b);
    logic ok;
    ok = ((b & ContMask) == ContTag);
    if (pos == 2'd1) begin
      if (lead == LeadThreeLo && b < ContE0Min) ok = 1'b0;
      if (lead == LeadSurr && b >= ContE0Min) ok = 1'b0;
      if (lead == LeadFourLo && b < ContF0Min) ok = 1'b0;
      if (lead == LeadFourHi && b > ContF4Max) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [7:0] latin1_hi(input logic [7:0] b);
    return Latin1Hi | {6'd0, b[7:6]};
  endfunction

  function automatic logic [7:0] latin1_lo(input logic [7:0] b);
    return ContTag | (b & Latin1Mask);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/uvl_front.sv -----
// Front end: tracks the held sequence and builds the result bytes of each input byte.
`default_nettype none

module uvl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               final_byte,
  output logic               push,
  output uvl_pkg::uvl_entry_t entry
);
  import uvl_pkg::*;

  logic [7:0] held_lead, held_lead_next;
  logic [1:0] held_count, held_count_next;
  logic [7:0] held_conts [2];

  logic [MaxOut-1:0][7:0] list;
  logic [3:0]             n;
  logic                   fresh;
  logic                   wr0, wr1;
  logic [7:0]             c0_eff, c1_eff;

  always_comb begin
    list            = '0;
    n               = 4'd0;
    fresh           = 1'b0;
    wr0             = 1'b0;
    wr1             = 1'b0;
    held_lead_next  = held_lead;
    held_count_next = held_count;

    if (held_count == 2'd0) begin
      fresh = 1'b1;
    end else if (cont_ok(held_lead, held_count, in_byte)) begin
      if ({1'b0, held_count} + 3'd1 >= seq_len(held_lead)) begin
        list[n[2:0]] = held_lead; n = n + 4'd1;
        if (held_count >= 2'd2) begin
          list[n[2:0]] = held_conts[0]; n = n + 4'd1;
        end
        if (held_count >= 2'd3) begin
          list[n[2:0]] = held_conts[1]; n = n + 4'd1;
        end
        list[n[2:0]] = in_byte; n = n + 4'd1;
        held_count_next = 2'd0;
      end else begin
        wr0 = (held_count == 2'd1);
        wr1 = (held_count == 2'd2);
        held_count_next = held_count + 2'd1;
      end
    end else begin
      // Broken sequence: the lead and every held continuation go out as Latin-1.
      list[n[2:0]] = latin1_hi(held_lead); n = n + 4'd1;
      list[n[2:0]] = latin1_lo(held_lead); n = n + 4'd1;
      if (held_count >= 2'd2) begin
        list[n[2:0]] = latin1_hi(held_conts[0]); n = n + 4'd1;
        list[n[2:0]] = latin1_lo(held_conts[0]); n = n + 4'd1;
      end
      if (held_count >= 2'd3) begin
        list[n[2:0]] = latin1_hi(held_conts[1]); n = n + 4'd1;
        list[n[2:0]] = latin1_lo(held_conts[1]); n = n + 4'd1;
      end
      held_count_next = 2'd0;
      fresh = 1'b1;
    end

    if (fresh) begin
      if (in_byte < ContTag) begin
        list[n[2:0]] = in_byte; n = n + 4'd1;
      end else if (seq_len(in_byte) != 3'd0) begin
        held_lead_next  = in_byte;
        held_count_next = 2'd1;
      end else begin
        list[n[2:0]] = latin1_hi(in_byte); n = n + 4'd1;
        list[n[2:0]] = latin1_lo(in_byte); n = n + 4'd1;
      end
    end

    // A truncated sequence at end of string is flushed after this byte's output.
    c0_eff = wr0 ? in_byte : held_conts[0];
    c1_eff = wr1 ? in_byte : held_conts[1];
    if (final_byte && held_count_next != 2'd0) begin
      list[n[2:0]] = latin1_hi(held_lead_next); n = n + 4'd1;
      list[n[2:0]] = latin1_lo(held_lead_next); n = n + 4'd1;
      if (held_count_next >= 2'd2) begin
        list[n[2:0]] = latin1_hi(c0_eff); n = n + 4'd1;
        list[n[2:0]] = latin1_lo(c0_eff); n = n + 4'd1;
      end
      if (held_count_next >= 2'd3) begin
        list[n[2:0]] = latin1_hi(c1_eff); n = n + 4'd1;
        list[n[2:0]] = latin1_lo(c1_eff); n = n + 4'd1;
      end
      held_count_next = 2'd0;
    end
  end

  assign entry.bytes = list;
  assign entry.count = n;
  assign entry.fin   = final_byte;
  assign push        = take && (n != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead  <= '0;
      held_count <= '0;
    end else if (take) begin
      held_lead  <= held_lead_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr0) held_conts[0] <= in_byte;
    if (take && wr1) held_conts[1] <= in_byte;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/uvl_queue.sv -----
// Two-entry queue that decouples the byte classifier from the output serializer.
`default_nettype none

module uvl_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  uvl_pkg::uvl_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output uvl_pkg::uvl_entry_t head
);
  import uvl_pkg::*;

  uvl_entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/uvl_back.sv -----
// Back end: sends the bytes of the queue head one per transaction and tags the run ends.
`default_nettype none

module uvl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  uvl_pkg::uvl_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                run_end,
  output logic                string_end
);
  import uvl_pkg::*;

  logic [2:0] idx;
  logic       last;
  logic       sent;

  assign last       = ({1'b0, idx} + 4'd1 == head.count);
  assign out_valid  = !empty;
  assign out_byte   = head.bytes[idx];
  assign run_end    = last;
  assign string_end = last && head.fin;
  assign sent       = out_valid && !out_stall;
  assign pop        = sent && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (sent) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_validate_latin1_repair.sv -----
// Top level of the UTF-8 validator that repairs bad bytes as Latin-1 code points.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall  | in_byte, final_byte
//   output  | out       | out_valid / out_stall| out_byte, run_end, string_end
//
// Each input byte yields 0 to 8 output bytes, one per cycle while out_stall is low; its
// bytes are registered as one queue entry and sent once that entry reaches the queue head.
// ASCII and valid sequences sustain one byte per cycle while out_stall is low.
// The output serializer sets the pace, so a steady run of repairs holds back the input side.
// A two-entry queue lets the input side keep taking bytes while an output waits.
// Synchronous reset empties the queue and drops any held partial sequence.
// in_stall is high exactly when the queue is full.
`default_nettype none

module utf8_validate_latin1_repair (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end
);
  import uvl_pkg::*;

  uvl_entry_t entry, head;
  logic       push, pop, full, empty, take;

  assign in_stall = full;
  assign take     = in_valid && !full;

  uvl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .push       (push),
    .entry      (entry)
  );

  uvl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  uvl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/uvl_checker.sv -----
// Port-level checks for the UTF-8 validator, bound to its top level.
`default_nettype none

module uvl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       string_end
);

  // A stalled output transaction keeps its byte and tags.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_end)
                               && $stable(string_end))
    else $error("stalled output changed");

  // The end of a string is always the end of a run.
  a_string_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_end)
    else $error("string_end without run_end");

  // Reset empties the block.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // Input is only held off while output is pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending output");

endmodule

bind utf8_validate_latin1_repair uvl_checker u_uvl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .run_end    (run_end),
  .string_end (string_end)
);

`default_nettype wire

// ----- verif/utf8_validate_latin1_repair_tb.sv -----
// Testbench for utf8_validate_latin1_repair: directed and random text bytes checked against a byte-level predictor.
`timescale 1ns / 100ps

module utf8_validate_latin1_repair_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } clean_byte_t;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems = 40;

  logic       clk;
  logic       rst;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  text_byte_t  pending_bytes[$];
  clean_byte_t expected_out[$];
  logic [7:0]  burst[$];

  // Predictor copy of the partial sequence being held.
  logic [7:0] lead_h;
  logic [7:0] conts_h[2];
  int         held_n = 0;

  logic in_taken;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   mismatches = 0;
  int   cycle_count = 0;

  utf8_validate_latin1_repair u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int seq_bytes(input logic [7:0] b);
    if (b >= 8'hC2 && b <= 8'hDF) return 2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3;
    if (b >= 8'hF0 && b <= 8'hF4) return 4;
    return 0;
  endfunction

  function automatic logic cont_accepted(input logic [7:0] lead, input int pos,
                                         input logic [7:0] b);
    if (b[7:6] != 2'b10) return 1'b0;
    if (pos == 1) begin
      // Overlong, surrogate and beyond-range checks all sit on the first continuation.
      if (lead == 8'hE0 && b < 8'hA0) return 1'b0;
      if (lead == 8'hED && b >= 8'hA0) return 1'b0;
      if (lead == 8'hF0 && b < 8'h90) return 1'b0;
      if (lead == 8'hF4 && b > 8'h8F) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void put_latin1(input logic [7:0] b);
    burst.insert(burst.size(), {6'b110000, b[7:6]});
    burst.insert(burst.size(), {2'b10, b[5:0]});
  endfunction

  function automatic void start_fresh(input logic [7:0] b);
    if (b < 8'h80) begin
      burst.insert(burst.size(), b);
    end else if (seq_bytes(b) != 0) begin
      lead_h = b;
      held_n = 1;
    end else begin
      put_latin1(b);
    end
  endfunction

  // Held bytes leave as Latin-1, lead first, in arrival order.
  function automatic void flush_held();
    int k;
    put_latin1(lead_h);
    for (k = 0; k < held_n - 1; k++) put_latin1(conts_h[k]);
    held_n = 0;
  endfunction

  task automatic predict_repair(input logic [7:0] b, input logic fin);
    int          k;
    clean_byte_t e;
    burst.delete();
    if (held_n == 0) begin
      start_fresh(b);
    end else if (cont_accepted(lead_h, held_n, b)) begin
      if (held_n + 1 >= seq_bytes(lead_h)) begin
        burst.insert(burst.size(), lead_h);
        for (k = 0; k < held_n - 1; k++) burst.insert(burst.size(), conts_h[k]);
        burst.insert(burst.size(), b);
        held_n = 0;
      end else begin
        conts_h[held_n - 1] = b;
        held_n = held_n + 1;
      end
    end else begin
      flush_held();
      start_fresh(b);
    end
    if (fin && held_n != 0) flush_held();
    for (k = 0; k < burst.size(); k++) begin
      e.data = burst[k];
      e.run_end = (k == burst.size() - 1);
      e.string_end = (k == burst.size() - 1) && fin;
      expected_out.insert(expected_out.size(), e);
    end
  endtask

  function automatic logic [7:0] first_cont(input logic [7:0] lead);
    case (lead)
      8'hE0:   return 8'($urandom_range(8'hA0, 8'hBF));
      8'hED:   return 8'($urandom_range(8'h80, 8'h9F));
      8'hF0:   return 8'($urandom_range(8'h90, 8'hBF));
      8'hF4:   return 8'($urandom_range(8'h80, 8'h8F));
      default: return 8'($urandom_range(8'h80, 8'hBF));
    endcase
  endfunction

  // One string: mostly well-formed sequences, with some noise, broken and cut sequences.
  task automatic add_string();
    logic [7:0] u[$];
    logic [7:0] ld;
    text_byte_t t;
    int         kind;
    int         len;
    int         keep;
    int         base;
    int         k;
    logic       ends;
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        u.insert(u.size(), 8'($urandom_range(0, 127)));
      end else if (kind < 85) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       ld = 8'($urandom_range(8'hC2, 8'hDF));
          3:       ld = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 8'hE0 : 8'hED)
                                             : 8'($urandom_range(8'hE0, 8'hEF));
          default: ld = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 8'hF0 : 8'hF4)
                                             : 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        base = u.size();
        u.insert(u.size(), ld);
        u.insert(u.size(), first_cont(ld));
        repeat (len - 2) u.insert(u.size(), 8'h80 | 8'($urandom_range(0, 63)));
        if ($urandom_range(0, 99) < 12) begin
          keep = $urandom_range(1, len - 1);
          while (u.size() > base + keep) u.delete(u.size() - 1);
        end
      end else if (kind < 93) begin
        u.insert(u.size(), 8'($urandom_range(0, 255)));
      end else begin
        // A lead whose continuations are drawn without regard to its range limits.
        ld = 8'($urandom_range(8'hC2, 8'hF4));
        u.insert(u.size(), ld);
        repeat ($urandom_range(1, 3)) u.insert(u.size(), 8'h80 | 8'($urandom_range(0, 63)));
      end
    end
    ends = ($urandom_range(0, 99) < 85);
    for (k = 0; k < u.size(); k++) begin
      t.data = u[k];
      t.fin = ends && (k == u.size() - 1);
      pending_bytes.insert(pending_bytes.size(), t);
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_out.size() != 0)
      @(posedge clk);
  endtask

  // Driver: a new transaction is offered only after the previous one was taken.
  always @(negedge clk) begin : driver
    text_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_byte <= nxt.data;
        final_byte <= nxt.fin;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    clean_byte_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_repair(in_byte, final_byte);
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          $error("out_byte %02h arrived with no result expected", out_byte);
          mismatches++;
        end else begin
          want = expected_out.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            mismatches++;
          end
          if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, run_end);
            mismatches++;
          end
          if (string_end !== want.string_end) begin
            $error("string_end: expected %0b, got %0b", want.string_end, string_end);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("utf8_validate_latin1_repair test failed");
      $finish;
    end
  end

  initial begin : sequencer
    logic [8:0] dir_items[25];
    text_byte_t t;
    int         k;
    rst = 1'b1;
    send_idle_pct = 14;
    recv_stall_pct = 67;
    // Bit 8 marks the last byte of a string.
    dir_items = '{9'h000, 9'h17F,            // ASCII extremes
                  9'h0C2, 9'h080,            // smallest two-byte sequence
                  9'h0E0, 9'h09F,            // overlong three-byte form
                  9'h0ED, 9'h0A0,            // surrogate
                  9'h0F0, 9'h08F,            // overlong four-byte form
                  9'h0F4, 9'h090,            // beyond U+10FFFF
                  9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                  9'h080, 9'h0C1, 9'h0FF,    // bytes that can never lead
                  9'h0F1, 9'h080, 9'h080, 9'h0C0,  // broken after two continuations
                  9'h0E1, 9'h180};           // cut short by the end of the string
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (k = 0; k < 25; k++) begin
      t.data = dir_items[k][7:0];
      t.fin = dir_items[k][8];
      pending_bytes.insert(pending_bytes.size(), t);
    end
    // The sender holds off here until every result of the directed part is out.
    wait_idle();
    while (pending_bytes.size() < PhaseItems) add_string();
    wait_idle();
    send_idle_pct = 67;
    recv_stall_pct = 14;
    while (pending_bytes.size() < PhaseItems) add_string();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_bytes.size() < PhaseItems) add_string();
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("utf8_validate_latin1_repair test passed");
    end else begin
      $display("utf8_validate_latin1_repair test failed");
    end
    $finish;
  end

endmodule
